// ===== hdl/btpc_pkg.sv =====
// Package for the barometric temperature and pressure compensation block.
// Holds stage numbering, register index codes, and partial-product helpers.
// No dependencies.
package btpc_pkg;

  localparam int DIV_W       = 64;
  localparam int ST_SIDE0    = 4;
  localparam int ST_DIVIN    = 12;
  localparam int ST_DIVLAST  = ST_DIVIN + DIV_W;
  localparam int NSTG        = ST_DIVLAST + 6;
  localparam int CFG_IDX_W   = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_TEMPERATURE = 8'd0,
    CFG_CAL_PRESSURE_A  = 8'd1,
    CFG_CAL_PRESSURE_B  = 8'd2,
    CFG_CAL_PRESSURE_C  = 8'd3
  } cfg_index_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] hi;
    logic [31:0] hi2;
  } pp_t;

  typedef struct packed {
    logic [31:0] temp;
    logic        inv;
    logic        neg;
  } side_t;

  function automatic pp_t pp_s16(input logic [63:0] x, input logic [15:0] c);
    pp_t r;
    logic signed [48:0] pr;
    pr = $signed({1'b0, x[31:0]}) * $signed(c);
    r.lo  = {{15{pr[48]}}, pr};
    r.hi  = x[63:32] * {{16{c[15]}}, c};
    r.hi2 = '0;
    return r;
  endfunction

  function automatic pp_t pp_u16(input logic [63:0] x, input logic [15:0] c);
    pp_t r;
    logic [47:0] pr;
    pr = x[31:0] * c;
    r.lo  = {16'b0, pr};
    r.hi  = x[63:32] * {16'b0, c};
    r.hi2 = '0;
    return r;
  endfunction

  function automatic pp_t pp_64(input logic [63:0] x, input logic [63:0] y);
    pp_t r;
    r.lo  = {32'b0, x[31:0]} * {32'b0, y[31:0]};
    r.hi  = x[31:0] * y[63:32];
    r.hi2 = x[63:32] * y[31:0];
    return r;
  endfunction

  function automatic logic [63:0] pp_sum(input pp_t p);
    logic [31:0] h;
    h = p.hi + p.hi2;
    return p.lo + {h, 32'b0};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] c);
    return {{48{c[15]}}, c};
  endfunction

endpackage

// ===== hdl/baro_temp_pressure_compensation_top.sv =====
// Top level of the barometric temperature and pressure compensation pipeline.
// Throughput is one item per cycle while the output is not stalled.
// The signed 64-bit division is a 64-stage restoring divider, one quotient bit a stage.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and the calibration registers to zero.
module baro_temp_pressure_compensation_top
  import btpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // adc_temperature[19:0], adc_pressure[39:20]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,   // temperature_centi[31:0], pressure_q24_8[63:32]
  output logic                 m_tuser,   // pressure_invalid
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [47:0] cal_t;
  logic [63:0] cal_a;
  logic [47:0] cal_b;
  logic [31:0] cal_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_t <= '0;
      cal_a <= '0;
      cal_b <= '0;
      cal_c <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CAL_TEMPERATURE: cal_t <= cfg_data[47:0];
        CFG_CAL_PRESSURE_A:  cal_a <= cfg_data;
        CFG_CAL_PRESSURE_B:  cal_b <= cfg_data[47:0];
        CFG_CAL_PRESSURE_C:  cal_c <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = cal_t[15:0];
  assign t2 = cal_t[31:16];
  assign t3 = cal_t[47:32];
  assign p1 = cal_a[15:0];
  assign p2 = cal_a[31:16];
  assign p3 = cal_a[47:32];
  assign p4 = cal_a[63:48];
  assign p5 = cal_b[15:0];
  assign p6 = cal_b[31:16];
  assign p7 = cal_b[47:32];
  assign p8 = cal_c[15:0];
  assign p9 = cal_c[31:16];

  logic [NSTG:1] vld;
  logic          adv;

  assign adv      = !vld[NSTG] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-1:1], s_tvalid};
    end
  end

  // temperature path
  logic [19:0] adc_t;
  logic [31:0] ta, tb;
  assign adc_t = s_tdata[19:0];
  assign ta = {15'b0, adc_t[19:3]} - {15'b0, t1, 1'b0};
  assign tb = {16'b0, adc_t[19:4]} - {16'b0, t1};

  logic [19:0] adcp [1:8];
  logic [31:0] s1_ma, s1_mb, s2_x1, s2_mc, s3_fine;
  logic [31:0] s2_sh, s3_fine5;
  logic [63:0] s4_v1;

  assign s2_sh    = 32'($signed(s1_mb) >>> 12);
  assign s3_fine5 = s3_fine * 32'd5 + 32'd128;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ma   <= ta * {{16{t2[15]}}, t2};
      s1_mb   <= tb * tb;
      adcp[1] <= s_tdata[39:20];
      s2_x1   <= 32'($signed(s1_ma) >>> 11);
      s2_mc   <= s2_sh * {{16{t3[15]}}, t3};
      s3_fine <= s2_x1 + 32'($signed(s2_mc) >>> 14);
      s4_v1   <= {{32{s3_fine[31]}}, s3_fine} - 64'd128000;
      for (int k = 2; k <= 8; k++) adcp[k] <= adcp[k-1];
    end
  end

  // side data: temperature result, invalid flag, quotient sign
  side_t sd [ST_SIDE0:NSTG];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[ST_SIDE0] <= '{temp: 32'($signed(s3_fine5) >>> 8), inv: 1'b0, neg: 1'b0};
    end
  end

  // pressure path before division
  pp_t         s5_sq, s5_p5, s5_p2, s7_sqp6, s7_sqp3, s9_u, s10_n;
  logic [63:0] s6_sq, s6_v1p5, s6_v1p2, s7_v1p5, s7_v1p2;
  logic [63:0] s8_v2, s8_vs, s9_pd, s10_v1f, s11_n, s11_d;
  logic [63:0] s8_sum3, s9_base, s9_u_in, s10_prod;

  assign s8_sum3  = pp_sum(s7_sqp3);
  assign s9_base  = 64'd1048576 - {44'b0, adcp[8]};
  assign s9_u_in  = 64'h0000_8000_0000_0000 + s8_vs;
  assign s10_prod = pp_sum(s9_u);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sq   <= pp_64(s4_v1, s4_v1);
      s5_p5   <= pp_s16(s4_v1, p5);
      s5_p2   <= pp_s16(s4_v1, p2);
      s6_sq   <= pp_sum(s5_sq);
      s6_v1p5 <= pp_sum(s5_p5);
      s6_v1p2 <= pp_sum(s5_p2);
      s7_sqp6 <= pp_s16(s6_sq, p6);
      s7_sqp3 <= pp_s16(s6_sq, p3);
      s7_v1p5 <= s6_v1p5;
      s7_v1p2 <= s6_v1p2;
      s8_v2   <= pp_sum(s7_sqp6) + (s7_v1p5 << 17) + (sx16(p4) << 35);
      s8_vs   <= 64'($signed(s8_sum3) >>> 8) + (s7_v1p2 << 12);
      s9_u    <= pp_u16(s9_u_in, p1);
      s9_pd   <= (s9_base << 31) - s8_v2;
      s10_v1f <= 64'($signed(s10_prod) >>> 33);
      s10_n   <= pp_u16(s9_pd, 16'd3125);
      s11_n   <= pp_sum(s10_n);
      s11_d   <= s10_v1f;
    end
  end

  // restoring divider on magnitudes
  logic [63:0] dv_rem [ST_DIVIN:ST_DIVLAST];
  logic [63:0] dv_n   [ST_DIVIN:ST_DIVLAST];
  logic [63:0] dv_q   [ST_DIVIN:ST_DIVLAST];
  logic [63:0] dv_d   [ST_DIVIN:ST_DIVLAST];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[ST_DIVIN] <= '0;
      dv_q[ST_DIVIN]   <= '0;
      dv_n[ST_DIVIN]   <= s11_n[63] ? (64'd0 - s11_n) : s11_n;
      dv_d[ST_DIVIN]   <= s11_d[63] ? (64'd0 - s11_d) : s11_d;
    end
  end

  for (genvar k = ST_DIVIN + 1; k <= ST_DIVLAST; k++) begin : g_div
    logic [64:0] trial;
    logic        ge;
    logic [64:0] diff;
    assign trial = {dv_rem[k-1], dv_n[k-1][63]};
    assign diff  = trial - {1'b0, dv_d[k-1]};
    assign ge    = trial >= {1'b0, dv_d[k-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k] <= ge ? diff[63:0] : trial[63:0];
        dv_n[k]   <= {dv_n[k-1][62:0], 1'b0};
        dv_q[k]   <= {dv_q[k-1][62:0], ge};
        dv_d[k]   <= dv_d[k-1];
      end
    end
  end

  for (genvar k = ST_SIDE0 + 1; k <= NSTG; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        if (k == ST_DIVIN) begin
          sd[k] <= '{temp: sd[k-1].temp, inv: (s11_d == 64'd0),
                     neg: s11_n[63] ^ s11_d[63]};
        end else begin
          sd[k] <= sd[k-1];
        end
      end
    end
  end

  // pressure path after division
  logic [63:0] f1_p, f2_p, f2_q, f3_p, f3_p9q, f3_w2, f3_q, f4_p, f4_w2, f5_p, f5_w1, f5_w2;
  pp_t         f2_pa, f2_pb, f4_pc;
  logic [63:0] f1_q13, f3_pb, f5_pc, fo_sum, fo_res;

  assign f1_q13 = 64'($signed(f1_p) >>> 13);
  assign f3_pb  = pp_sum(f2_pb);
  assign f5_pc  = pp_sum(f4_pc);
  assign fo_sum = f5_p + f5_w1 + f5_w2;
  assign fo_res = 64'($signed(fo_sum) >>> 8) + (sx16(p7) << 4);

  logic [31:0] out_t, out_p;
  logic        out_inv;

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_p    <= sd[ST_DIVLAST].neg ? (64'd0 - dv_q[ST_DIVLAST]) : dv_q[ST_DIVLAST];
      f2_pa   <= pp_s16(f1_q13, p9);
      f2_pb   <= pp_s16(f1_p, p8);
      f2_p    <= f1_p;
      f2_q    <= f1_q13;
      f3_p9q  <= pp_sum(f2_pa);
      f3_w2   <= 64'($signed(f3_pb) >>> 19);
      f3_p    <= f2_p;
      f3_q    <= f2_q;
      f4_pc   <= pp_64(f3_p9q, f3_q);
      f4_p    <= f3_p;
      f4_w2   <= f3_w2;
      f5_w1   <= 64'($signed(f5_pc) >>> 25);
      f5_p    <= f4_p;
      f5_w2   <= f4_w2;
      out_p   <= sd[NSTG-1].inv ? 32'd0 : fo_res[31:0];
      out_t   <= sd[NSTG-1].temp;
      out_inv <= sd[NSTG-1].inv;
    end
  end

  assign m_tdata = {out_p, out_t};
  assign m_tuser = out_inv;

endmodule

// ===== hdl/btpc_checker.sv =====
// Port-level checker for the compensation pipeline, bound to its top level.
// Depends on baro_temp_pressure_compensation_top port names.
module btpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[63:32] == 32'd0)
    else $error("invalid pressure not forced to zero");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind baro_temp_pressure_compensation_top btpc_checker u_btpc_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== tb/baro_temp_pressure_compensation_top_tb.sv =====
// Testbench for the barometric temperature and pressure compensation pipeline.
// Drives raw ADC pairs and calibration writes, predicts each result and compares.
// Depends on btpc_pkg and baro_temp_pressure_compensation_top.
module baro_temp_pressure_compensation_top_tb
  import btpc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] pres;
    logic        inv;
  } comp_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [47:0] cal_t, cal_b;
  logic [63:0] cal_a;
  logic [31:0] cal_c;

  logic [39:0] adc_queue[$];
  comp_t       expected_q[$];
  int          errors = 0;
  int          burst = 0, gap = 0;
  bit          hold = 0;
  int          stall_mode = 0;

  baro_temp_pressure_compensation_top u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic comp_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
    comp_t r;
    logic [31:0] t1, t2, t3, a, b, x1, x2, fine;
    logic [63:0] v1, v2, p, q, w1, w2, n, d, an, ad, qq;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    t1 = {16'b0, cal_t[15:0]};
    t2 = {{16{cal_t[31]}}, cal_t[31:16]};
    t3 = {{16{cal_t[47]}}, cal_t[47:32]};
    a = {15'b0, adc_t[19:3]} - (t1 << 1);
    x1 = asr32(a * t2, 11);
    b = {16'b0, adc_t[19:4]} - t1;
    x2 = asr32(asr32(b * b, 12) * t3, 14);
    fine = x1 + x2;
    r.temp = asr32(fine * 32'd5 + 32'd128, 8);
    p1 = {48'b0, cal_a[15:0]};
    p2 = {{48{cal_a[31]}}, cal_a[31:16]};
    p3 = {{48{cal_a[47]}}, cal_a[47:32]};
    p4 = {{48{cal_a[63]}}, cal_a[63:48]};
    p5 = {{48{cal_b[15]}}, cal_b[15:0]};
    p6 = {{48{cal_b[31]}}, cal_b[31:16]};
    p7 = {{48{cal_b[47]}}, cal_b[47:32]};
    p8 = {{48{cal_c[15]}}, cal_c[15:0]};
    p9 = {{48{cal_c[31]}}, cal_c[31:16]};
    v1 = {{32{fine[31]}}, fine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
    r.pres = '0;
    r.inv = 0;
    if (v1 == 0) begin
      r.inv = 1;
    end else begin
      p = 64'd1048576 - {44'b0, adc_p};
      n = ((p << 31) - v2) * 64'd3125;
      d = v1;
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      qq = an / ad;
      p = (n[63] != d[63]) ? -qq : qq;
      q = asr64(p, 13);
      w1 = asr64(p9 * q * q, 25);
      w2 = asr64(p8 * p, 19);
      p = asr64(p + w1 + w2, 8) + (p7 << 4);
      r.pres = p[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_q.push_back(compensate(s_tdata[19:0], s_tdata[39:20]));
        adc_queue.pop_front();
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1;
      end else if (hold || adc_queue.size() == 0) begin
        s_tvalid <= 0;
      end else if (gap > 0) begin
        gap--;
        s_tvalid <= 0;
      end else begin
        s_tvalid <= 1;
        s_tdata <= adc_queue[0];
        if (burst > 0) begin
          burst--;
        end else begin
          burst = $urandom_range(0, 20);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(posedge clk) begin
    comp_t w;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
        end else begin
          w = expected_q.pop_front();
          if (m_tdata[31:0] !== w.temp) report_mismatch("temperature", m_tdata[31:0], w.temp);
          if (m_tdata[63:32] !== w.pres) report_mismatch("pressure", m_tdata[63:32], w.pres);
          if (m_tuser !== w.inv) report_mismatch("invalid", m_tuser, w.inv);
        end
      end
      case (stall_mode)
        0: m_tready <= 1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_cal(cfg_index_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CAL_TEMPERATURE: cal_t = val[47:0];
      CFG_CAL_PRESSURE_A:  cal_a = val;
      CFG_CAL_PRESSURE_B:  cal_b = val[47:0];
      default:             cal_c = val[31:0];
    endcase
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (adc_queue.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_typical();
    write_cal(CFG_CAL_TEMPERATURE, {16'hFE18, 16'd26435, 16'd27504});
    write_cal(CFG_CAL_PRESSURE_A, {16'd2855, 16'd8192, 16'hD0D0, 16'd36477});
    write_cal(CFG_CAL_PRESSURE_B, {16'd15500, 16'hFFF9, 16'd140});
    write_cal(CFG_CAL_PRESSURE_C, {16'd6000, 16'hC004});
  endtask

  task automatic jitter_cal();
    write_cal(CFG_CAL_TEMPERATURE, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
    write_cal(CFG_CAL_PRESSURE_A, {$urandom, $urandom});
    write_cal(CFG_CAL_PRESSURE_B, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
    write_cal(CFG_CAL_PRESSURE_C, {32'b0, $urandom});
  endtask

  task automatic add_random(int count);
    repeat (count) begin
      adc_queue.push_back({20'($urandom_range(0, 20'hFFFFF)),
                           20'($urandom_range(0, 20'hFFFFF))});
    end
  endtask

  initial begin
    cal_t = '0; cal_a = '0; cal_b = '0; cal_c = '0;
    repeat (2) @(posedge clk);
    rst <= 0;
    // reset calibration: zero divisor on every item
    adc_queue.push_back({20'h0, 20'h0});
    adc_queue.push_back({20'hFFFFF, 20'hFFFFF});
    drain();
    load_typical();
    adc_queue.push_back({20'd415148, 20'd519888});
    adc_queue.push_back({20'h0, 20'h0});
    adc_queue.push_back({20'hFFFFF, 20'hFFFFF});
    adc_queue.push_back({20'h0, 20'hFFFFF});
    adc_queue.push_back({20'hFFFFF, 20'h0});
    adc_queue.push_back({20'h55555, 20'hAAAAA});
    adc_queue.push_back({20'hAAAAA, 20'h55555});
    drain();
    write_cal(CFG_CAL_TEMPERATURE, 64'hFFFF_FFFF_FFFF);
    write_cal(CFG_CAL_PRESSURE_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(CFG_CAL_PRESSURE_B, 64'hFFFF_FFFF_FFFF);
    write_cal(CFG_CAL_PRESSURE_C, 64'hFFFF_FFFF);
    adc_queue.push_back({20'h0, 20'h0});
    adc_queue.push_back({20'hFFFFF, 20'hFFFFF});
    adc_queue.push_back({20'h80000, 20'h7FFFF});
    drain();
    write_cal(CFG_CAL_TEMPERATURE, 64'h8000_8000_FFFF);
    write_cal(CFG_CAL_PRESSURE_A, 64'h8000_8000_8000_0001);
    write_cal(CFG_CAL_PRESSURE_B, 64'h7FFF_7FFF_8000);
    write_cal(CFG_CAL_PRESSURE_C, 64'h8000_7FFF);
    adc_queue.push_back({20'h0, 20'hFFFFF});
    adc_queue.push_back({20'hFFFFF, 20'h0});
    adc_queue.push_back({20'h12345, 20'h6789A});
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 3;
      if (ph % 2 == 0) load_typical();
      else jitter_cal();
      add_random(60);
      if (ph == 2) begin
        while (adc_queue.size() > 30) @(posedge clk);
        hold = 1;
        while (s_tvalid || expected_q.size() > 0) @(posedge clk);
        hold = 0;
      end
      add_random(60);
      drain();
    end
    if (errors == 0) begin
      $display("[baro_temp_pressure_compensation_top] OK");
    end else begin
      $display("[baro_temp_pressure_compensation_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[baro_temp_pressure_compensation_top] ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/btpc_pkg.sv
hdl/baro_temp_pressure_compensation_top.sv
hdl/btpc_checker.sv
tb/baro_temp_pressure_compensation_top_tb.sv
